// ===== rtl/core/triangle_unit_normal_core_defines.svh =====
// ----------------------------------------------------------------------------
// Triangle unit normal core: assertion macros
// Shared concurrent assertion forms used by the core's checks.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TUN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TUN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define TUN_ASSERT_NXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tun_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Default parameters, fixed datapath widths and stage side-band types.
// ----------------------------------------------------------------------------
package tun_pkg;

    // Default coordinate width and output fraction width.
    localparam int COORD_BITS    = 16;
    localparam int OUT_FRAC_BITS = 14;

    // Output component width.
    localparam int OUT_W = 16;

    // Normalized magnitude width (top bit at position 30).
    localparam int MW = 31;
    // Sum of squares width and square root result width.
    localparam int SUMW = 64;
    localparam int QRW  = 32;
    // Square root steps, one result bit each.
    localparam int SQ_STEPS = SUMW / 2;
    // Square root partial remainder width.
    localparam int SQ_REMW = QRW + 2;

    // Side band carried through the square root stages.
    typedef struct packed {
        logic [2:0][MW-1:0] m;
        logic [2:0]         neg;
        logic               deg;
    } t_sq_side;

    // Side band carried through the division stages.
    typedef struct packed {
        logic [QRW-1:0] q;
        logic [2:0]     neg;
        logic           deg;
    } t_dv_side;

endpackage

// ===== rtl/core/triangle_unit_normal_core.sv =====
// ----------------------------------------------------------------------------
// Triangle unit normal core
// Cross product of two triangle edges, normalized to a signed unit vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries the nine vertex coordinates of one
//   triangle (A, B, C; signed Q8.8). Output channel o_valid/i_ready carries
//   the unit normal in signed Q1.OUT_FRAC_BITS and a degenerate flag; a
//   triangle whose cross product is zero gives zero components and the flag.
//   Every triangle gives exactly one result, in order.
//   From transfer in to result valid, a triangle passes nine setup and
//   scaling stages, 32 square root stages of one root bit each, one divide
//   setup stage, one stage per quotient bit of the three parallel
//   dividers, and the output register.
//   Throughput is one triangle per cycle while the pipeline is not stalled;
//   the square root and divider chains are fully pipelined.
//   Reset clears every valid bit; payload registers are not reset.
//   When the receiver holds i_ready low with a result waiting, the whole
//   pipeline freezes and o_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "triangle_unit_normal_core_defines.svh"

module triangle_unit_normal_core #(
    parameter int COORD_BITS    = tun_pkg::COORD_BITS,
    parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic signed [COORD_BITS-1:0] i_a_z,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic signed [COORD_BITS-1:0] i_b_z,
    input  logic signed [COORD_BITS-1:0] i_c_x,
    input  logic signed [COORD_BITS-1:0] i_c_y,
    input  logic signed [COORD_BITS-1:0] i_c_z,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [tun_pkg::OUT_W-1:0] o_normal_x,
    output logic signed [tun_pkg::OUT_W-1:0] o_normal_y,
    output logic signed [tun_pkg::OUT_W-1:0] o_normal_z,
    output logic                         o_degenerate
);

    localparam int CB   = COORD_BITS;
    localparam int EW   = CB + 1;
    localparam int DW   = (EW > 31) ? 31 : EW;
    localparam int PRW  = 2 * DW;
    localparam int NMW  = 2 * DW;
    localparam int NG   = (NMW + 7) / 8;
    localparam int PW   = $clog2(NG * 8);
    localparam int MW   = tun_pkg::MW;
    localparam int QRW  = tun_pkg::QRW;
    localparam int SQS  = tun_pkg::SQ_STEPS;
    localparam int SRW  = tun_pkg::SQ_REMW;
    localparam int SUMW = tun_pkg::SUMW;
    localparam int SQW  = 2 * MW;
    localparam int F    = OUT_FRAC_BITS;
    localparam int QW   = F + 1;
    localparam int NW   = MW + F + 1;
    localparam int OW   = tun_pkg::OUT_W;

    // Whole pipeline advances when the output register is free or drained.
    logic w_adv;
    logic r_o_vld;
    assign w_adv   = !r_o_vld || i_ready;
    assign o_ready = w_adv;

    // ------------------------------------------------------------------
    // Stage 1: edge vectors as sign and magnitude.
    // ------------------------------------------------------------------
    logic                 r1_vld;
    logic [CB-1:0]        r1_mag [6];
    logic [5:0]           r1_neg;
    logic [CB-1:0]        n1_mag [6];
    logic [5:0]           n1_neg;

    always_comb begin
        logic [EW-1:0] e [6];
        e[0] = {i_b_x[CB-1], i_b_x} - {i_a_x[CB-1], i_a_x};
        e[1] = {i_b_y[CB-1], i_b_y} - {i_a_y[CB-1], i_a_y};
        e[2] = {i_b_z[CB-1], i_b_z} - {i_a_z[CB-1], i_a_z};
        e[3] = {i_c_x[CB-1], i_c_x} - {i_a_x[CB-1], i_a_x};
        e[4] = {i_c_y[CB-1], i_c_y} - {i_a_y[CB-1], i_a_y};
        e[5] = {i_c_z[CB-1], i_c_z} - {i_a_z[CB-1], i_a_z};
        for (int i = 0; i < 6; i++) begin
            n1_neg[i] = e[i][EW-1];
            n1_mag[i] = n1_neg[i] ? CB'(-e[i]) : CB'(e[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cut wide edges so the largest stays below 2^30.
    // ------------------------------------------------------------------
    logic                 r2_vld;
    logic signed [DW-1:0] r2_d [6];
    logic signed [DW-1:0] n2_d [6];

    always_comb begin
        logic [CB-1:0] orm;
        logic [1:0]    sh;
        logic [CB-1:0] sm;
        orm = '0;
        sh  = '0;
        sm  = '0;
        for (int i = 0; i < 6; i++) begin
            orm = orm | r1_mag[i];
        end
        for (int k = 30; k < CB; k++) begin
            if (orm[k]) begin
                sh = 2'(k - 29);
            end
        end
        for (int i = 0; i < 6; i++) begin
            sm      = r1_mag[i] >> sh;
            n2_d[i] = r1_neg[i] ? -DW'(sm) : DW'(sm);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the six partial products of the cross product.
    // ------------------------------------------------------------------
    logic                  r3_vld;
    logic signed [PRW-1:0] r3_p [6];
    logic signed [PRW-1:0] n3_p [6];

    always_comb begin
        n3_p[0] = r2_d[1] * r2_d[5];
        n3_p[1] = r2_d[2] * r2_d[4];
        n3_p[2] = r2_d[2] * r2_d[3];
        n3_p[3] = r2_d[0] * r2_d[5];
        n3_p[4] = r2_d[0] * r2_d[4];
        n3_p[5] = r2_d[1] * r2_d[3];
    end

    // ------------------------------------------------------------------
    // Stage 4: cross product components as sign and magnitude.
    // ------------------------------------------------------------------
    logic            r4_vld;
    logic [NMW-1:0]  r4_nmag [3];
    logic [2:0]      r4_nneg;
    logic            r4_deg;
    logic [NMW-1:0]  n4_nmag [3];
    logic [2:0]      n4_nneg;
    logic            n4_deg;

    always_comb begin
        logic [PRW:0] nv [3];
        for (int i = 0; i < 3; i++) begin
            nv[i] = {r3_p[2*i][PRW-1], r3_p[2*i]} - {r3_p[2*i+1][PRW-1], r3_p[2*i+1]};
            n4_nneg[i] = nv[i][PRW];
            n4_nmag[i] = n4_nneg[i] ? NMW'(-nv[i]) : NMW'(nv[i]);
        end
        n4_deg = (nv[0] == '0) && (nv[1] == '0) && (nv[2] == '0);
    end

    // ------------------------------------------------------------------
    // Stage 5: leading-one search, per byte group.
    // ------------------------------------------------------------------
    logic            r5_vld;
    logic [NMW-1:0]  r5_nmag [3];
    logic [2:0]      r5_nneg;
    logic            r5_deg;
    logic [NG-1:0]   r5_gnz;
    logic [2:0]      r5_gpos [NG];
    logic [NG-1:0]   n5_gnz;
    logic [2:0]      n5_gpos [NG];

    always_comb begin
        logic [NG*8-1:0] orp;
        orp = (NG*8)'(r4_nmag[0] | r4_nmag[1] | r4_nmag[2]);
        for (int g = 0; g < NG; g++) begin
            n5_gnz[g]  = |orp[g*8 +: 8];
            n5_gpos[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (orp[g*8 + b]) begin
                    n5_gpos[g] = 3'(b);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: leading-one position across groups.
    // ------------------------------------------------------------------
    logic            r6_vld;
    logic [NMW-1:0]  r6_nmag [3];
    logic [2:0]      r6_nneg;
    logic            r6_deg;
    logic [PW-1:0]   r6_p;
    logic [PW-1:0]   n6_p;

    always_comb begin
        n6_p = '0;
        for (int g = 0; g < NG; g++) begin
            if (r5_gnz[g]) begin
                n6_p = PW'(g * 8) | PW'(r5_gpos[g]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: shift so the largest magnitude has its top bit at 30.
    // ------------------------------------------------------------------
    logic              r7_vld;
    tun_pkg::t_sq_side r7_side;
    tun_pkg::t_sq_side n7_side;

    always_comb begin
        logic [6:0]        pw;
        logic [NMW+MW-1:0] ext;
        pw = 7'(r6_p);
        for (int i = 0; i < 3; i++) begin
            ext = (NMW+MW)'(r6_nmag[i]);
            if (pw > 7'd30) begin
                n7_side.m[i] = MW'(ext >> (pw - 7'd30));
            end else begin
                n7_side.m[i] = MW'(ext << (7'd30 - pw));
            end
        end
        n7_side.neg = r6_nneg;
        n7_side.deg = r6_deg;
    end

    // ------------------------------------------------------------------
    // Stages 8 and 9: squares, then their sum.
    // ------------------------------------------------------------------
    logic              r8_vld;
    logic [SQW-1:0]    r8_sq [3];
    tun_pkg::t_sq_side r8_side;
    logic              r9_vld;
    logic [SUMW-1:0]   r9_sum;
    tun_pkg::t_sq_side r9_side;

    // ------------------------------------------------------------------
    // Square root: one root bit per stage.
    // ------------------------------------------------------------------
    logic              r_sq_vld  [SQS];
    logic [SRW-1:0]    r_sq_rem  [SQS];
    logic [QRW-1:0]    r_sq_root [SQS];
    logic [SUMW-1:0]   r_sq_val  [SQS];
    tun_pkg::t_sq_side r_sq_side [SQS];
    logic              n_sq_vld  [SQS];
    logic [SRW-1:0]    n_sq_rem  [SQS];
    logic [QRW-1:0]    n_sq_root [SQS];
    logic [SUMW-1:0]   n_sq_val  [SQS];
    tun_pkg::t_sq_side n_sq_side [SQS];

    always_comb begin
        logic [SRW-1:0]  rem;
        logic [QRW-1:0]  root;
        logic [SUMW-1:0] val;
        logic [SRW+1:0]  trial;
        logic [SRW+1:0]  tv;
        for (int k = 0; k < SQS; k++) begin
            if (k == 0) begin
                rem          = '0;
                root         = '0;
                val          = r9_sum;
                n_sq_vld[k]  = r9_vld;
                n_sq_side[k] = r9_side;
            end else begin
                rem          = r_sq_rem[k-1];
                root         = r_sq_root[k-1];
                val          = r_sq_val[k-1];
                n_sq_vld[k]  = r_sq_vld[k-1];
                n_sq_side[k] = r_sq_side[k-1];
            end
            trial = {rem, val[SUMW-1 -: 2]};
            tv    = {2'b00, root, 2'b01};
            if (trial >= tv) begin
                n_sq_rem[k]  = SRW'(trial - tv);
                n_sq_root[k] = {root[QRW-2:0], 1'b1};
            end else begin
                n_sq_rem[k]  = SRW'(trial);
                n_sq_root[k] = {root[QRW-2:0], 1'b0};
            end
            n_sq_val[k] = {val[SUMW-3:0], 2'b00};
        end
    end

    // ------------------------------------------------------------------
    // Divide setup: rounded numerators and the starting remainders.
    // ------------------------------------------------------------------
    logic                   r_ds_vld;
    logic [2:0][QRW-1:0]    r_ds_rem;
    logic [2:0][QW-1:0]     r_ds_low;
    tun_pkg::t_dv_side      r_ds_side;
    logic [2:0][QRW-1:0]    n_ds_rem;
    logic [2:0][QW-1:0]     n_ds_low;
    tun_pkg::t_dv_side      n_ds_side;

    always_comb begin
        logic [QRW-1:0] q;
        logic [NW-1:0]  num;
        q = r_sq_root[SQS-1];
        for (int i = 0; i < 3; i++) begin
            num         = (NW'(r_sq_side[SQS-1].m[i]) << F) + NW'(q[QRW-1:1]);
            n_ds_rem[i] = QRW'(num[NW-1:QW]);
            n_ds_low[i] = num[QW-1:0];
        end
        n_ds_side.q   = q;
        n_ds_side.neg = r_sq_side[SQS-1].neg;
        n_ds_side.deg = r_sq_side[SQS-1].deg;
    end

    // ------------------------------------------------------------------
    // Three restoring dividers, one quotient bit per stage.
    // ------------------------------------------------------------------
    logic                r_dv_vld  [QW];
    logic [2:0][QRW-1:0] r_dv_rem  [QW];
    logic [2:0][QW-1:0]  r_dv_low  [QW];
    tun_pkg::t_dv_side   r_dv_side [QW];
    logic                n_dv_vld  [QW];
    logic [2:0][QRW-1:0] n_dv_rem  [QW];
    logic [2:0][QW-1:0]  n_dv_low  [QW];
    tun_pkg::t_dv_side   n_dv_side [QW];

    always_comb begin
        logic [2:0][QRW-1:0] rem;
        logic [2:0][QW-1:0]  low;
        logic [QRW:0]        trial;
        logic                ge;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                rem          = r_ds_rem;
                low          = r_ds_low;
                n_dv_vld[k]  = r_ds_vld;
                n_dv_side[k] = r_ds_side;
            end else begin
                rem          = r_dv_rem[k-1];
                low          = r_dv_low[k-1];
                n_dv_vld[k]  = r_dv_vld[k-1];
                n_dv_side[k] = r_dv_side[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                trial = {rem[i], low[i][QW-1]};
                ge    = trial >= {1'b0, n_dv_side[k].q};
                n_dv_rem[k][i] = ge ? QRW'(trial - {1'b0, n_dv_side[k].q}) : QRW'(trial);
                n_dv_low[k][i] = {low[i][QW-2:0], ge};
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: saturate, apply the sign, zero degenerate results.
    // ------------------------------------------------------------------
    logic [OW-1:0] r_o_nrm [3];
    logic          r_o_deg;
    logic [OW-1:0] n_o_nrm [3];

    always_comb begin
        logic [QW-1:0] one;
        logic [QW-1:0] r;
        logic [63:0]   rv;
        one = QW'(1) << F;
        for (int i = 0; i < 3; i++) begin
            r  = r_dv_low[QW-1][i];
            if (r > one) begin
                r = one;
            end
            rv = 64'(r);
            if (r_dv_side[QW-1].neg[i]) begin
                rv = -rv;
            end
            n_o_nrm[i] = r_dv_side[QW-1].deg ? '0 : rv[OW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Valid bits: reset and advance with the pipeline.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld   <= 1'b0;
            r2_vld   <= 1'b0;
            r3_vld   <= 1'b0;
            r4_vld   <= 1'b0;
            r5_vld   <= 1'b0;
            r6_vld   <= 1'b0;
            r7_vld   <= 1'b0;
            r8_vld   <= 1'b0;
            r9_vld   <= 1'b0;
            r_ds_vld <= 1'b0;
            r_o_vld  <= 1'b0;
            for (int k = 0; k < SQS; k++) begin
                r_sq_vld[k] <= 1'b0;
            end
            for (int k = 0; k < QW; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r1_vld   <= i_valid;
            r2_vld   <= r1_vld;
            r3_vld   <= r2_vld;
            r4_vld   <= r3_vld;
            r5_vld   <= r4_vld;
            r6_vld   <= r5_vld;
            r7_vld   <= r6_vld;
            r8_vld   <= r7_vld;
            r9_vld   <= r8_vld;
            r_ds_vld <= r_sq_vld[SQS-1];
            r_o_vld  <= r_dv_vld[QW-1];
            for (int k = 0; k < SQS; k++) begin
                r_sq_vld[k] <= n_sq_vld[k];
            end
            for (int k = 0; k < QW; k++) begin
                r_dv_vld[k] <= n_dv_vld[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: load on advance, no reset.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_mag  <= n1_mag;
            r1_neg  <= n1_neg;
            r2_d    <= n2_d;
            r3_p    <= n3_p;
            r4_nmag <= n4_nmag;
            r4_nneg <= n4_nneg;
            r4_deg  <= n4_deg;
            r5_nmag <= r4_nmag;
            r5_nneg <= r4_nneg;
            r5_deg  <= r4_deg;
            r5_gnz  <= n5_gnz;
            r5_gpos <= n5_gpos;
            r6_nmag <= r5_nmag;
            r6_nneg <= r5_nneg;
            r6_deg  <= r5_deg;
            r6_p    <= n6_p;
            r7_side <= n7_side;
            for (int i = 0; i < 3; i++) begin
                r8_sq[i] <= SQW'(r7_side.m[i]) * SQW'(r7_side.m[i]);
            end
            r8_side   <= r7_side;
            r9_sum    <= SUMW'(r8_sq[0]) + SUMW'(r8_sq[1]) + SUMW'(r8_sq[2]);
            r9_side   <= r8_side;
            r_sq_rem  <= n_sq_rem;
            r_sq_root <= n_sq_root;
            r_sq_val  <= n_sq_val;
            r_sq_side <= n_sq_side;
            r_ds_rem  <= n_ds_rem;
            r_ds_low  <= n_ds_low;
            r_ds_side <= n_ds_side;
            r_dv_rem  <= n_dv_rem;
            r_dv_low  <= n_dv_low;
            r_dv_side <= n_dv_side;
            r_o_nrm   <= n_o_nrm;
            r_o_deg   <= r_dv_side[QW-1].deg;
        end
    end

    assign o_valid      = r_o_vld;
    assign o_normal_x   = r_o_nrm[0];
    assign o_normal_y   = r_o_nrm[1];
    assign o_normal_z   = r_o_nrm[2];
    assign o_degenerate = r_o_deg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `TUN_ASSERT_IMP(a_deg_zero, o_valid && o_degenerate,
        (o_normal_x == '0) && (o_normal_y == '0) && (o_normal_z == '0),
        "degenerate result with nonzero components")
    `TUN_ASSERT_NXT(a_stall_hold, !w_adv,
        $stable(r_sq_vld[SQS-1]) && $stable(r_ds_vld) && $stable(r_dv_vld[QW-1]),
        "pipeline valid bits moved during a stall")
    `TUN_ASSERT_NXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_normal_x) && $stable(o_degenerate),
        "waiting result changed before its transfer")
    `TUN_ASSERT_NXT_RST(a_rst_clear, !i_rst_n,
        !o_valid && !r1_vld && !r_ds_vld,
        "valid bits not cleared by reset")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Triangle unit normal core testbench
// Streams triangles through the core and checks every unit normal against
// an integer predictor of the cross product, length and rounding.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB  = tun_pkg::COORD_BITS;
    localparam int OFB = tun_pkg::OUT_FRAC_BITS;
    localparam int OW  = tun_pkg::OUT_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic signed [CB-1:0] v [9];
    } t_tri;

    typedef struct {
        logic [OW-1:0] nx, ny, nz;
        logic          deg;
    } t_normal;

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic signed [CB-1:0] i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z;
    logic signed [CB-1:0] i_c_x, i_c_y, i_c_z;
    logic signed [OW-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic o_degenerate;

    triangle_unit_normal_core dut (.*);

    t_tri    tri_pending [$];
    t_normal normal_expected [$];
    int send_idle_pct, recv_stall_pct;
    int mismatches, results_seen, cycles, degen_seen;
    bit in_fire;

    // Integer square root, floor.
    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Predicts the unit normal of one triangle.
    function automatic t_normal unit_normal_of(t_tri t);
        t_normal r;
        longint d [6];
        longint n [3];
        logic [63:0] m [3], mx, sum, q, one, rr;
        int p;
        logic [OW-1:0] comp [3];
        for (int i = 0; i < 3; i++) begin
            d[i]   = longint'(t.v[3+i]) - longint'(t.v[i]);
            d[3+i] = longint'(t.v[6+i]) - longint'(t.v[i]);
        end
        // Edges of 16-bit coordinates never reach bit 30, so no edge cut.
        n[0] = d[1]*d[5] - d[2]*d[4];
        n[1] = d[2]*d[3] - d[0]*d[5];
        n[2] = d[0]*d[4] - d[1]*d[3];
        if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            r.nx = 0; r.ny = 0; r.nz = 0; r.deg = 1;
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = n[i] < 0 ? 64'(-n[i]) : 64'(n[i]);
            if (m[i] > mx) mx = m[i];
        end
        p = -1;
        for (int b = 0; b < 64; b++) if (mx[b]) p = b;
        for (int i = 0; i < 3; i++) begin
            if (p > 30) m[i] = m[i] >> (p - 30);
            else m[i] = m[i] << (30 - p);
        end
        sum = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
        q = root_floor(sum);
        one = 64'd1 << OFB;
        for (int i = 0; i < 3; i++) begin
            rr = ((m[i] << OFB) + (q >> 1)) / q;
            if (rr > one) rr = one;
            if (n[i] < 0) rr = -rr;
            comp[i] = rr[OW-1:0];
        end
        r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2]; r.deg = 0;
        return r;
    endfunction

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return (CB)'($urandom_range(0, 1) ? 32767 : -32768);
            1: return (CB)'($urandom_range(0, 15)) - 8;
            default: return (CB)'($urandom);
        endcase
    endfunction

    task automatic push_tri(input t_tri t);
        tri_pending.push_back(t);
        normal_expected.push_back(unit_normal_of(t));
    endtask

    // Clock.
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: presents pending triangles, changes inputs at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || in_fire) begin
            // A transfer seen at the last rising edge retires the head item.
            if (in_fire) void'(tri_pending.pop_front());
            if (tri_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid <= 1;
                {i_a_x, i_a_y, i_a_z} <= {tri_pending[0].v[0], tri_pending[0].v[1],
                                          tri_pending[0].v[2]};
                {i_b_x, i_b_y, i_b_z} <= {tri_pending[0].v[3], tri_pending[0].v[4],
                                          tri_pending[0].v[5]};
                {i_c_x, i_c_y, i_c_z} <= {tri_pending[0].v[6], tri_pending[0].v[7],
                                          tri_pending[0].v[8]};
            end else begin
                i_valid <= 0;
            end
        end
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: records input transfers and checks each result transfer.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        in_fire <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (normal_expected.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                t_normal e;
                e = normal_expected.pop_front();
                if (o_degenerate) degen_seen <= degen_seen + 1;
                if (e.nx !== o_normal_x || e.ny !== o_normal_y ||
                    e.nz !== o_normal_z || e.deg !== o_degenerate) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                                 $signed(e.nx), $signed(e.ny), $signed(e.nz), e.deg,
                                 o_normal_x, o_normal_y, o_normal_z, o_degenerate);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", normal_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus and phase control.
    initial begin
        t_tri t;
        int pct_s [4];
        int pct_r [4];
        pct_s = '{0, 63, 0, 19};
        pct_r = '{0, 0, 63, 19};
        i_rst_n = 0; i_valid = 0; i_ready = 0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z} = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        mismatches = 0; results_seen = 0; cycles = 0; degen_seen = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: degenerate cases, extremes, axis-aligned and rounding cases.
        foreach (t.v[i]) t.v[i] = 0;
        push_tri(t);
        foreach (t.v[i]) t.v[i] = 16'sh7fff;
        push_tri(t);
        foreach (t.v[i]) t.v[i] = (i % 3 == 0) ? 16'sh7fff : 16'sh8000;
        push_tri(t);
        // Collinear vertices.
        t.v = '{0, 0, 0, 256, 256, 256, 512, 512, 512};
        push_tri(t);
        t.v = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
        push_tri(t);
        t.v = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
        push_tri(t);
        t.v = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
        push_tri(t);
        t.v = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
        push_tri(t);
        t.v = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
        push_tri(t);
        t.v = '{-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768};
        push_tri(t);
        t.v = '{0, 0, 0, 1, 1, 0, 0, 1, 1};
        push_tri(t);
        t.v = '{0, 0, 0, 3, 1, 2, 1, 3, 7};
        push_tri(t);
        t.v = '{5, -7, 9, 5, -7, 9, 100, 200, 300};
        push_tri(t);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = pct_s[ph];
            recv_stall_pct = pct_r[ph];
            for (int k = 0; k < 285; k++) begin
                foreach (t.v[i]) t.v[i] = rand_coord();
                // Some collinear or coincident triangles.
                if ($urandom_range(0, 19) == 0)
                    for (int i = 0; i < 3; i++) t.v[6+i] = t.v[3+i];
                else if ($urandom_range(0, 19) == 0)
                    for (int i = 0; i < 3; i++) t.v[3+i] = t.v[i];
                push_tri(t);
            end
            wait (normal_expected.size() == 0);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Streamed %0d triangles (%0d degenerate) under four idle/stall mixes.",
                 results_seen, degen_seen);
        if (mismatches == 0 && normal_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tun_pkg.sv
rtl/core/triangle_unit_normal_core.sv
tb/tb_top.sv
